>>> design/cdq_pkg.sv
package cdq_pkg;

    // Queue geometry and field widths
    localparam int DEPTH  = 8;
    localparam int DATA_W = 32;
    localparam int OCC_W  = 4;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 2;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_F = 3'd0,
        REQ_PUSH_R = 3'd1,
        REQ_POP_F  = 3'd2,
        REQ_POP_R  = 3'd3,
        REQ_PEEK_F = 3'd4,
        REQ_PEEK_R = 3'd5
    } t_req;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // Operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,
        OP_SHR    = 3'd1,
        OP_SHL    = 3'd2,
        OP_PUSH_R = 3'd3,
        OP_POP_R  = 3'd4
    } t_cell_op;

endpackage

>>> design/cdq_cell.sv
module cdq_cell import cdq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_op          i_op,
    input  logic [DATA_W-1:0] i_push_value,
    input  logic              i_left_valid,
    input  logic [DATA_W-1:0] i_left_data,
    input  logic              i_right_valid,
    input  logic [DATA_W-1:0] i_right_data,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    output logic              o_is_rear
);

    logic              r_valid;
    logic              n_valid;
    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // Pick the next word: take from a neighbor, load the pushed item, or hold
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        case (i_op)
            OP_SHR: begin
                n_valid = i_left_valid;
                n_data  = i_left_data;
            end
            OP_SHL: begin
                n_valid = i_right_valid;
                n_data  = i_right_data;
            end
            OP_PUSH_R: begin
                // first empty cell whose left neighbor is occupied (or the front cell) takes the item
                if (!r_valid && i_left_valid) begin
                    n_valid = 1'b1;
                    n_data  = i_push_value;
                end
            end
            OP_POP_R: begin
                // last occupied cell drops its word
                if (r_valid && !i_right_valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Occupied flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Stored word
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid   = r_valid;
    assign o_data    = r_data;
    assign o_is_rear = r_valid && !i_right_valid;

endmodule

>>> design/circular_deque.sv
// A result appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless a result waits with i_out_ready
// low; the output register is refilled while its item is being taken.
// Reset (i_rst_n low at a clock edge) empties the queue and drops any
// pending result; stored words keep whatever they held.
module circular_deque import cdq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [DATA_W-1:0] i_push_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [DATA_W-1:0] o_out_value,
    output logic [OCC_W-1:0]  o_occupancy
);

    logic [DEPTH-1:0]  w_valid;
    logic [DATA_W-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]  w_is_rear;
    logic [DEPTH-1:0]  w_left_valid;
    logic [DATA_W-1:0] w_left_data [DEPTH];
    logic [DEPTH-1:0]  w_right_valid;
    logic [DATA_W-1:0] w_right_data [DEPTH];

    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic [DATA_W-1:0] w_front;
    logic [DATA_W-1:0] w_rear;
    t_req              w_req;
    t_cell_op          w_op;
    t_cell_op          n_op;

    logic              r_out_valid;
    logic              n_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [DATA_W-1:0] r_out_value;
    logic [DATA_W-1:0] n_out_value;
    logic [OCC_W-1:0]  r_count;
    logic [OCC_W-1:0]  n_count;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_req      = t_req'(i_req_type);
    assign w_full     = w_valid[DEPTH-1];
    assign w_empty    = !w_valid[0];
    assign w_front    = w_data[0];

    // Gather the rear word from the cell that marks itself as last
    always_comb begin
        w_rear = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rear = w_rear | (w_data[i] & {DATA_W{w_is_rear[i]}});
        end
    end

    // Decode the request into a row operation and a result
    always_comb begin
        n_op        = OP_HOLD;
        n_status    = ST_OK;
        n_out_value = '0;
        n_count     = r_count;
        case (w_req)
            REQ_PUSH_F, REQ_PUSH_R: begin
                if (w_full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_op    = (w_req == REQ_PUSH_F) ? OP_SHR : OP_PUSH_R;
                    n_count = r_count + OCC_W'(1);
                end
            end
            REQ_POP_F, REQ_POP_R: begin
                if (w_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_op        = (w_req == REQ_POP_F) ? OP_SHL : OP_POP_R;
                    n_out_value = (w_req == REQ_POP_F) ? w_front : w_rear;
                    n_count     = r_count - OCC_W'(1);
                end
            end
            REQ_PEEK_F, REQ_PEEK_R: begin
                if (w_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_out_value = (w_req == REQ_PEEK_F) ? w_front : w_rear;
                end
            end
            default: begin
            end
        endcase
    end

    // Drive the row only for an accepted item
    assign w_op = w_accept ? n_op : OP_HOLD;

    // Wire each cell to its neighbors; the front cell sees the pushed item
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_front
            assign w_left_valid[g] = 1'b1;
            assign w_left_data[g]  = i_push_value;
        end else begin : g_inner
            assign w_left_valid[g] = w_valid[g-1];
            assign w_left_data[g]  = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_back
            assign w_right_valid[g] = 1'b0;
            assign w_right_data[g]  = '0;
        end else begin : g_mid
            assign w_right_valid[g] = w_valid[g+1];
            assign w_right_data[g]  = w_data[g+1];
        end

        cdq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (w_op),
            .i_push_value  (i_push_value),
            .i_left_valid  (w_left_valid[g]),
            .i_left_data   (w_left_data[g]),
            .i_right_valid (w_right_valid[g]),
            .i_right_data  (w_right_data[g]),
            .o_valid       (w_valid[g]),
            .o_data        (w_data[g]),
            .o_is_rear     (w_is_rear[g])
        );
    end

    // Output valid: set on accept, clear when taken
    assign n_out_valid = w_accept ? 1'b1 : (r_out_valid && !i_out_ready);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_out_value <= n_out_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_value = r_out_value;
    assign o_occupancy = r_count;

`ifndef ASSERT_OFF
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == OCC_W'($countones(w_valid)))
        else $error("occupancy counter disagrees with occupied cells");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OCC_W'(DEPTH))
        else $error("occupancy exceeds depth");

    a_overflow_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_full && (w_req == REQ_PUSH_F || w_req == REQ_PUSH_R)
        |=> o_out_valid && o_status == ST_OVERFLOW && $stable(w_valid))
        else $error("push into full queue not rejected");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_empty && (w_req == REQ_POP_F || w_req == REQ_POP_R)
        |=> r_count == $past(r_count) - OCC_W'(1))
        else $error("pop did not remove one word");
`endif

endmodule
